FILE: hw/rtl/rcu_pkg.sv
// ============================================================================
// rcu_pkg
// Shared widths, constants, types and the month table for the RTC calendar
// to Unix millisecond converter.
// ============================================================================
package rcu_pkg;

    // field widths of one calendar reading
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SUBSEC_W = 15;
    localparam int FRAC_W   = 15;

    // result width
    localparam int MS_W = 42;

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // bit offsets of the input fields in tdata
    localparam int YEAR_LSB   = 0;
    localparam int MONTH_LSB  = YEAR_LSB + YEAR_W;
    localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
    localparam int HOUR_LSB   = DAY_LSB + DAY_W;
    localparam int MIN_LSB    = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB    = MIN_LSB + MIN_W;
    localparam int SUBSEC_LSB = SEC_LSB + SEC_W;

    // internal widths of the date path
    localparam int LEAPS_W = 6;
    localparam int MSTART_W = 9;
    localparam int DAYS_W = 16;
    localparam int HRS_W  = 21;
    localparam int MINS_W = 27;
    localparam int SECS_W = 33;

    // divider widths: quotient below 1024, numerator below 2^25
    localparam int Q_W   = 10;
    localparam int NUM_W = 25;
    localparam int DEN_W = FRAC_W + 1;
    localparam int DIV_CELLS = Q_W;

    // date pipeline depth
    localparam int DATE_STAGES = 5;

    // constants
    localparam logic [DAYS_W-1:0] DAYS_1970_TO_2000 = DAYS_W'(10957);
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR     = DAYS_W'(365);
    localparam logic [FRAC_W-1:0] FRAC_RESET        = FRAC_W'(255);
    localparam logic [NUM_W-1:0]  MS_PER_SEC_NUM    = NUM_W'(1000);
    localparam logic [MS_W-1:0]   MS_PER_SEC        = MS_W'(1000);
    localparam logic [YEAR_W-1:0] YEAR_2100         = YEAR_W'(100);
    localparam logic [MONTH_W-1:0] MONTH_JAN        = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_MAR        = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_DEC        = MONTH_W'(12);

    // one item travelling down the divider chain
    typedef struct packed {
        logic [NUM_W-1:0] rem;    // running remainder
        logic [NUM_W-1:0] dsh;    // divisor aligned to the current quotient bit
        logic [Q_W-1:0]   quo;    // quotient bits so far
        logic [MS_W-1:0]  ms_whole;
        logic             err;
    } t_div_item;

    // days before the first of a month in a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/rcu_date.sv
// ============================================================================
// rcu_date
// Front pipeline: day count, range check, rounding numerator, then hours,
// minutes, seconds and whole milliseconds one constant product per stage.
// ============================================================================
module rcu_date (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rcu_pkg::FRAC_W-1:0]          i_second_fraction,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rcu_pkg::IN_TDATA_W-1:0]      i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rcu_pkg::t_div_item                  o_item
);

    // stage valid flags and per-stage ready
    logic [rcu_pkg::DATE_STAGES-1:0] r_vld;
    logic [rcu_pkg::DATE_STAGES-1:0] w_rdy;

    // field unpack
    logic [rcu_pkg::YEAR_W-1:0]   w_year;
    logic [rcu_pkg::MONTH_W-1:0]  w_month;
    logic [rcu_pkg::DAY_W-1:0]    w_day;
    logic [rcu_pkg::HOUR_W-1:0]   w_hours;
    logic [rcu_pkg::MIN_W-1:0]    w_minutes;
    logic [rcu_pkg::SEC_W-1:0]    w_seconds;
    logic [rcu_pkg::SUBSEC_W-1:0] w_subsec;

    // first stage logic
    logic [rcu_pkg::LEAPS_W-1:0]  w_leaps;
    logic                         w_leap_year;
    logic                         w_err;
    logic [rcu_pkg::FRAC_W-1:0]   w_ticks;
    logic [rcu_pkg::DEN_W-1:0]    w_denom;
    logic [rcu_pkg::NUM_W-1:0]    n_s1_numer;
    logic [rcu_pkg::DAYS_W-1:0]   n_s1_days;

    // stage registers
    logic [rcu_pkg::DAYS_W-1:0]   r_s1_days;
    logic [rcu_pkg::HOUR_W-1:0]   r_s1_hours;
    logic [rcu_pkg::MIN_W-1:0]    r_s1_minutes;
    logic [rcu_pkg::SEC_W-1:0]    r_s1_seconds;
    logic [rcu_pkg::HRS_W-1:0]    r_s2_hrs;
    logic [rcu_pkg::MIN_W-1:0]    r_s2_minutes;
    logic [rcu_pkg::SEC_W-1:0]    r_s2_seconds;
    logic [rcu_pkg::MINS_W-1:0]   r_s3_mins;
    logic [rcu_pkg::SEC_W-1:0]    r_s3_seconds;
    logic [rcu_pkg::SECS_W-1:0]   r_s4_secs;
    logic [rcu_pkg::DATE_STAGES-2:0] r_err;
    logic [rcu_pkg::NUM_W-1:0]    r_numer [rcu_pkg::DATE_STAGES-1];
    logic [rcu_pkg::NUM_W-1:0]    r_dsh   [rcu_pkg::DATE_STAGES-1];
    rcu_pkg::t_div_item           r_out;

    // ready chain from the far end
    always_comb begin
        w_rdy[rcu_pkg::DATE_STAGES-1] = !r_vld[rcu_pkg::DATE_STAGES-1] || i_ready;
        for (int k = rcu_pkg::DATE_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[rcu_pkg::DATE_STAGES-1];
    assign o_item  = r_out;

    // unpack the input transfer
    assign w_year    = i_data[rcu_pkg::YEAR_LSB   +: rcu_pkg::YEAR_W];
    assign w_month   = i_data[rcu_pkg::MONTH_LSB  +: rcu_pkg::MONTH_W];
    assign w_day     = i_data[rcu_pkg::DAY_LSB    +: rcu_pkg::DAY_W];
    assign w_hours   = i_data[rcu_pkg::HOUR_LSB   +: rcu_pkg::HOUR_W];
    assign w_minutes = i_data[rcu_pkg::MIN_LSB    +: rcu_pkg::MIN_W];
    assign w_seconds = i_data[rcu_pkg::SEC_LSB    +: rcu_pkg::SEC_W];
    assign w_subsec  = i_data[rcu_pkg::SUBSEC_LSB +: rcu_pkg::SUBSEC_W];

    // leap years since 2000, with 2100 dropped
    always_comb begin
        w_leaps = rcu_pkg::LEAPS_W'((8'(w_year) + 8'd3) >> 2)
                - rcu_pkg::LEAPS_W'(w_year > rcu_pkg::YEAR_2100);
        w_leap_year = (w_year[1:0] == 2'b00) && (w_year != rcu_pkg::YEAR_2100);
    end

    // whole days before the given day
    always_comb begin
        n_s1_days = rcu_pkg::DAYS_1970_TO_2000
                  + rcu_pkg::DAYS_W'(w_year) * rcu_pkg::DAYS_PER_YEAR
                  + rcu_pkg::DAYS_W'(w_leaps)
                  + rcu_pkg::DAYS_W'(rcu_pkg::month_start(w_month))
                  + rcu_pkg::DAYS_W'(w_leap_year && (w_month >= rcu_pkg::MONTH_MAR))
                  + rcu_pkg::DAYS_W'(w_day)
                  - rcu_pkg::DAYS_W'(1);
    end

    // range check and rounding numerator for the subsecond part
    always_comb begin
        w_err   = (w_month < rcu_pkg::MONTH_JAN) || (w_month > rcu_pkg::MONTH_DEC)
               || (w_subsec > i_second_fraction);
        w_ticks = i_second_fraction - w_subsec;
        w_denom = rcu_pkg::DEN_W'(i_second_fraction) + rcu_pkg::DEN_W'(1);
        if (w_err) begin
            n_s1_numer = '0;
        end else begin
            n_s1_numer = rcu_pkg::NUM_W'(w_ticks) * rcu_pkg::MS_PER_SEC_NUM
                       + rcu_pkg::NUM_W'(w_denom >> 1);
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < rcu_pkg::DATE_STAGES; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // error flag, numerator and aligned divisor carried along the date stages
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_err[0]   <= w_err;
            r_numer[0] <= n_s1_numer;
            r_dsh[0]   <= rcu_pkg::NUM_W'(w_denom) << (rcu_pkg::Q_W - 1);
        end
        for (int k = 1; k < rcu_pkg::DATE_STAGES - 1; k++) begin
            if (w_rdy[k] && r_vld[k-1]) begin
                r_err[k]   <= r_err[k-1];
                r_numer[k] <= r_numer[k-1];
                r_dsh[k]   <= r_dsh[k-1];
            end
        end
    end

    // stage 1: days and time fields
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s1_days    <= n_s1_days;
            r_s1_hours   <= w_hours;
            r_s1_minutes <= w_minutes;
            r_s1_seconds <= w_seconds;
        end
    end

    // stage 2: hours since epoch
    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && r_vld[0]) begin
            r_s2_hrs     <= rcu_pkg::HRS_W'(r_s1_days) * rcu_pkg::HRS_W'(24)
                          + rcu_pkg::HRS_W'(r_s1_hours);
            r_s2_minutes <= r_s1_minutes;
            r_s2_seconds <= r_s1_seconds;
        end
    end

    // stage 3: minutes since epoch
    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && r_vld[1]) begin
            r_s3_mins    <= rcu_pkg::MINS_W'(r_s2_hrs) * rcu_pkg::MINS_W'(60)
                          + rcu_pkg::MINS_W'(r_s2_minutes);
            r_s3_seconds <= r_s2_seconds;
        end
    end

    // stage 4: seconds since epoch
    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && r_vld[2]) begin
            r_s4_secs  <= rcu_pkg::SECS_W'(r_s3_mins) * rcu_pkg::SECS_W'(60)
                        + rcu_pkg::SECS_W'(r_s3_seconds);
        end
    end

    // stage 5: whole milliseconds, wrapped to the result width
    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && r_vld[3]) begin
            r_out.ms_whole <= rcu_pkg::MS_W'(r_s4_secs) * rcu_pkg::MS_PER_SEC;
            r_out.err      <= r_err[3];
            r_out.rem      <= r_numer[3];
            r_out.dsh      <= r_dsh[3];
            r_out.quo      <= '0;
        end
    end

endmodule

FILE: hw/rtl/rcu_div_cell.sv
// ============================================================================
// rcu_div_cell
// One cell of the divider chain: resolves one quotient bit by compare and
// subtract, then hands the item and the halved divisor to the next cell.
// ============================================================================
module rcu_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rcu_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rcu_pkg::t_div_item o_item
);

    logic               r_valid;
    rcu_pkg::t_div_item r_item;
    rcu_pkg::t_div_item n_item;
    logic               w_take;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign w_take  = i_valid && o_ready;

    // one restoring division step
    always_comb begin
        n_item = i_item;
        if (i_item.rem >= i_item.dsh) begin
            n_item.rem = i_item.rem - i_item.dsh;
            n_item.quo = {i_item.quo[rcu_pkg::Q_W-2:0], 1'b1};
        end else begin
            n_item.quo = {i_item.quo[rcu_pkg::Q_W-2:0], 1'b0};
        end
        n_item.dsh = i_item.dsh >> 1;
    end

    // cell valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/rtc_calendar_to_unix_ms_core.sv
// ============================================================================
// rtc_calendar_to_unix_ms_core
// RTC calendar reading to Unix epoch milliseconds, fully pipelined.
// ============================================================================
// A new calendar reading can be taken every clock cycle while a stalled
// output has not backed up the pipeline, and each one gives exactly one
// result after five date stages (day count, then hours, minutes, seconds
// and milliseconds one constant product each), ten divider cells that
// each resolve one bit of the rounded subsecond milliseconds, and the
// output register. Every stage holds its item only while the next one is
// full, so a stalled output does not stop input transfers until the
// pipeline has filled. A bad month or a subsecond count above the
// prescaler returns zero with the range error flag set. Write the
// prescaler only while no conversion is in flight.
module rtc_calendar_to_unix_ms_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // prescaler register
    input  logic                               i_cfg_wr_en,
    input  logic [rcu_pkg::FRAC_W-1:0]         i_cfg_wr_data,
    // calendar input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // year_since_2000, month, day, hours, minutes, seconds, subsecond_count
    input  logic [rcu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // millisecond output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // unix_ms, zero padding
    output logic [rcu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // range_error
    output logic                               m_axis_tuser
);

    logic [rcu_pkg::FRAC_W-1:0] r_second_fraction;

    // chain links: index 0 is the date pipeline output
    logic                 w_vld [rcu_pkg::DIV_CELLS+1];
    logic                 w_rdy [rcu_pkg::DIV_CELLS+1];
    rcu_pkg::t_div_item   w_item [rcu_pkg::DIV_CELLS+1];

    logic                 w_out_rdy;
    logic                 r_out_valid;
    logic [rcu_pkg::MS_W-1:0] r_out_ms;
    logic                 r_out_err;
    logic [rcu_pkg::MS_W-1:0] n_out_ms;

    // prescaler register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_fraction <= rcu_pkg::FRAC_RESET;
        end else if (i_cfg_wr_en) begin
            r_second_fraction <= i_cfg_wr_data;
        end
    end

    // date and numerator pipeline
    rcu_date u_date (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_second_fraction (r_second_fraction),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_data            (s_axis_tdata),
        .o_valid           (w_vld[0]),
        .i_ready           (w_rdy[0]),
        .o_item            (w_item[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < rcu_pkg::DIV_CELLS; g++) begin : g_cell
        rcu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_item  (w_item[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign w_out_rdy = !r_out_valid || m_axis_tready;
    assign w_rdy[rcu_pkg::DIV_CELLS] = w_out_rdy;

    // add the rounded fraction, force zero on a range error
    always_comb begin
        if (w_item[rcu_pkg::DIV_CELLS].err) begin
            n_out_ms = '0;
        end else begin
            n_out_ms = w_item[rcu_pkg::DIV_CELLS].ms_whole
                     + rcu_pkg::MS_W'(w_item[rcu_pkg::DIV_CELLS].quo);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= w_vld[rcu_pkg::DIV_CELLS];
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_vld[rcu_pkg::DIV_CELLS]) begin
            r_out_ms  <= n_out_ms;
            r_out_err <= w_item[rcu_pkg::DIV_CELLS].err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = rcu_pkg::OUT_TDATA_W'(r_out_ms);
    assign m_axis_tuser  = r_out_err;

endmodule
